/* rtl/matrix_vector_transform_4x4_defines.svh */
// Assertion macros for the 4x4 matrix-vector transform
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define MVT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvt assertion failed");
// implication with a fixed delay in cycles
`define MVT_ASSERT_DLY(name, ante, dly, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("mvt assertion failed");
`else
`define MVT_ASSERT_IMP(name, ante, cons)
`define MVT_ASSERT_DLY(name, ante, dly, cons)
`endif

`endif

/* rtl/mvt_pkg.sv */
// Shared types and constants for the 4x4 matrix-vector transform
package mvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int NROW      = 4;
    localparam int NCOL      = 4;
    localparam int NHALF     = 2;
    localparam int NREG      = 8;
    localparam int REGW      = 64;
    localparam int IDXW      = 3;
    localparam int PRODW     = 2 * DW;
    localparam int PAIRW     = PRODW + 1;
    localparam int SUMW      = PRODW + 3;
    localparam int SHW       = SUMW - FRAC_BITS;
    localparam int PIPE_LAT  = 4;

    typedef logic signed [DW-1:0]    q_t;
    typedef logic signed [PRODW-1:0] prod_t;
    typedef logic signed [PAIRW-1:0] pair_t;
    typedef logic signed [SUMW-1:0]  sum_t;
    typedef logic [REGW-1:0]         cfg_word_t;
    typedef logic [IDXW-1:0]         cfg_idx_t;

    typedef q_t    vec_t  [NCOL];
    typedef q_t    mat_t  [NROW][NCOL];
    typedef prod_t prod_mat_t [NROW][NCOL];
    typedef sum_t  sum_vec_t  [NROW];

    // register indexes
    localparam cfg_idx_t R0_C01 = 3'd0;
    localparam cfg_idx_t R0_C23 = 3'd1;
    localparam cfg_idx_t R1_C01 = 3'd2;
    localparam cfg_idx_t R1_C23 = 3'd3;
    localparam cfg_idx_t R2_C01 = 3'd4;
    localparam cfg_idx_t R2_C23 = 3'd5;
    localparam cfg_idx_t R3_C01 = 3'd6;
    localparam cfg_idx_t R3_C23 = 3'd7;

    localparam cfg_word_t ID_LO = 64'd65536;
    localparam cfg_word_t ID_HI = 64'd65536 << DW;

    localparam q_t SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam q_t SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    localparam sum_t RND = sum_t'(1) << (FRAC_BITS - 1);

    // identity matrix at reset
    function automatic cfg_word_t reg_reset(input cfg_idx_t idx);
        cfg_word_t v;
        case (idx) inside
            R0_C01, R2_C23: v = ID_LO;
            R1_C01, R3_C23: v = ID_HI;
            default:        v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/mvt_mul.sv */
// Stage 1: sixteen 32x32 signed products
module mvt_mul
    import mvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid,
    input  vec_t      vec,
    input  mat_t      mat,
    output logic      prod_valid,
    output prod_mat_t prod
);

    logic      valid_reg;
    prod_mat_t prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            for (int r = 0; r < NROW; r++)
            begin
                for (int c = 0; c < NCOL; c++)
                begin
                    prod_reg[r][c] <= prod_t'(mat[r][c]) * prod_t'(vec[c]);
                end
            end
        end
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

/* rtl/mvt_acc.sv */
// Stages 2 and 3: pairwise sums, then row sum plus rounding half-LSB
module mvt_acc
    import mvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      prod_valid,
    input  prod_mat_t prod,
    output logic      sum_valid,
    output sum_vec_t  sum
);

    pair_t    pair_reg [NROW][NHALF];
    pair_t    pair_next [NROW][NHALF];
    sum_vec_t sum_reg;
    sum_vec_t sum_next;
    logic     pair_valid_reg;
    logic     sum_valid_reg;

    always_comb
    begin
        for (int r = 0; r < NROW; r++)
        begin
            for (int h = 0; h < NHALF; h++)
            begin
                pair_next[r][h] = pair_t'(prod[r][2*h]) + pair_t'(prod[r][2*h+1]);
            end
            sum_next[r] = sum_t'(pair_reg[r][0]) + sum_t'(pair_reg[r][1]) + RND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            pair_valid_reg <= prod_valid;
            sum_valid_reg  <= pair_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid)
            pair_reg <= pair_next;
        if (pair_valid_reg)
            sum_reg <= sum_next;
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

/* rtl/mvt_sat.sv */
// Stage 4: drop fraction bits, saturate to 32 bits, register the result
module mvt_sat
    import mvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sum_valid,
    input  sum_vec_t sum,
    output logic     res_valid,
    output vec_t     res,
    output logic     res_sat
);

    logic [SHW-1:0]  sh   [NROW];
    logic [SHW-DW:0] top  [NROW];
    logic [NROW-1:0] ovf;
    vec_t            res_next;
    vec_t            res_reg;
    logic            sat_reg;
    logic            valid_reg;

    always_comb
    begin
        for (int r = 0; r < NROW; r++)
        begin
            sh[r]  = sum[r][SUMW-1:FRAC_BITS];
            // bits above the result's sign must all copy it
            top[r] = sh[r][SHW-1:DW-1];
            ovf[r] = !((&top[r]) || !(|top[r]));
            if (ovf[r])
                res_next[r] = sh[r][SHW-1] ? SAT_MIN : SAT_MAX;
            else
                res_next[r] = sh[r][DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= sum_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid)
        begin
            res_reg <= res_next;
            sat_reg <= |ovf;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;
    assign res_sat   = sat_reg;

endmodule

/* rtl/matrix_vector_transform_4x4.sv */
// Top level: matrix registers and the four-stage transform pipeline
//
// channel   direction  handshake        payload
// config    in         cfg_we           cfg_index, cfg_data (64b, two Q16.16 entries)
// vector    in         start && !busy   in_x, in_y, in_z, in_w
// result    out        done (1 cycle)   out_x, out_y, out_z, out_w, saturated
//
// One vector per cycle; each result passes through four registered stages:
// multiply, pair add, row add with rounding, saturate and output register.
// busy stays low: the pipeline never stalls since the result side cannot.
// Reset loads the identity matrix and clears all valid bits.
`include "matrix_vector_transform_4x4_defines.svh"

module matrix_vector_transform_4x4
    import mvt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDXW-1:0]  cfg_index,
    input  logic [REGW-1:0]  cfg_data,
    input  logic             start,
    output logic             busy,
    input  logic [DW-1:0]    in_x,
    input  logic [DW-1:0]    in_y,
    input  logic [DW-1:0]    in_z,
    input  logic [DW-1:0]    in_w,
    output logic             done,
    output logic [DW-1:0]    out_x,
    output logic [DW-1:0]    out_y,
    output logic [DW-1:0]    out_z,
    output logic [DW-1:0]    out_w,
    output logic             saturated
);

    cfg_word_t cfg_reg [NREG];
    mat_t      mat;
    vec_t      vec;
    logic      accept;
    logic      prod_valid;
    prod_mat_t prod;
    logic      sum_valid;
    sum_vec_t  sum;
    vec_t      res;
    logic      clamp_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
                cfg_reg[i] <= reg_reset(cfg_idx_t'(i));
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // register 2r+h: column 2h in the low word, column 2h+1 in the high word
    always_comb
    begin
        for (int r = 0; r < NROW; r++)
        begin
            for (int c = 0; c < NCOL; c++)
            begin
                mat[r][c] = cfg_reg[2*r + c/2][(c%2)*DW +: DW];
            end
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign vec[0] = in_x;
    assign vec[1] = in_y;
    assign vec[2] = in_z;
    assign vec[3] = in_w;

    mvt_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (accept),
        .vec        (vec),
        .mat        (mat),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    mvt_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .sum_valid  (sum_valid),
        .sum        (sum)
    );

    mvt_sat u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_valid  (sum_valid),
        .sum        (sum),
        .res_valid  (done),
        .res        (res),
        .res_sat    (saturated)
    );

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];
    assign out_w = res[3];

    // some component sits at a rail
    assign clamp_seen = (out_x == SAT_MAX) || (out_x == SAT_MIN)
                     || (out_y == SAT_MAX) || (out_y == SAT_MIN)
                     || (out_z == SAT_MAX) || (out_z == SAT_MIN)
                     || (out_w == SAT_MAX) || (out_w == SAT_MIN);

    `MVT_ASSERT_DLY(a_beat_gives_result, start && !busy, PIPE_LAT, done)
    `MVT_ASSERT_IMP(a_result_has_beat, done, $past(start && !busy, PIPE_LAT))
    `MVT_ASSERT_IMP(a_sat_clamps, done && saturated, clamp_seen)

endmodule
